@@ rtl/ipcv_pkg.sv @@
// ipcv_pkg: shared constants and types for the ipv4 cidr string validator
// no dependencies; used by ipcv_parser, the top level and the checker

package ipcv_pkg;

  localparam int CharW    = 8;
  localparam int PrefixW  = 6;
  localparam int OctetW   = 8;
  localparam int DotW     = 2;
  localparam int DigitW   = 4;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;
  localparam int OutDataW = 8;

  localparam logic [CharW-1:0]   CharSlash = 8'h2F;
  localparam logic [CharW-1:0]   CharDot   = 8'h2E;
  localparam logic [CharW-1:0]   CharZero  = 8'h30;
  localparam logic [CharW-1:0]   CharNine  = 8'h39;

  localparam logic [OctetW-1:0]  MaxOctet  = 8'd255;
  localparam logic [PrefixW-1:0] PrefixSat = 6'd63;
  localparam logic [DotW-1:0]    LastDot   = 2'd3;

  // input kind codes
  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxMinPrefix = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxMaxPrefix = 1'b1;

  localparam logic [PrefixW-1:0] MinPrefixRst = 6'd1;
  localparam logic [PrefixW-1:0] MaxPrefixRst = 6'd31;

  typedef struct packed {
    logic                in_prefix;
    logic [DotW-1:0]     dot_count;
    logic                has_digit;
    logic [OctetW-1:0]   octet;
    logic [PrefixW-1:0]  prefix;
    logic                failed;
  } parse_state_t;

  typedef struct packed {
    logic [PrefixW-1:0]  min_prefix;
    logic [PrefixW-1:0]  max_prefix;
  } bounds_t;

  typedef struct packed {
    logic                ok;
    logic [PrefixW-1:0]  prefix_len;
  } result_t;

endpackage

@@ rtl/ipcv_parser.sv @@
// ipcv_parser: per-character parse state and end-of-string verdict
// depends on ipcv_pkg

module ipcv_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic                          kind,
  input  logic [ipcv_pkg::CharW-1:0]    ch,
  input  ipcv_pkg::bounds_t             bounds,
  output ipcv_pkg::result_t             res
);

  localparam int OctAccW = ipcv_pkg::OctetW + 4;
  localparam int PreAccW = ipcv_pkg::PrefixW + 4;

  ipcv_pkg::parse_state_t st_r, st_nxt;

  logic                          digit;
  logic [ipcv_pkg::DigitW-1:0]   dval;
  logic [OctAccW-1:0]            oct_acc;
  logic [PreAccW-1:0]            pre_acc;
  logic                          ok;

  assign digit = (ch >= ipcv_pkg::CharZero) && (ch <= ipcv_pkg::CharNine);
  assign dval  = digit ? ipcv_pkg::DigitW'(ch - ipcv_pkg::CharZero) : '0;

  // value * 10 + digit as two shifts and adds
  assign oct_acc = (OctAccW'(st_r.octet) << 3) + (OctAccW'(st_r.octet) << 1)
                 + OctAccW'(dval);
  assign pre_acc = (PreAccW'(st_r.prefix) << 3) + (PreAccW'(st_r.prefix) << 1)
                 + PreAccW'(dval);

  always_comb begin
    st_nxt = st_r;
    if (kind == ipcv_pkg::KindEnd) begin
      st_nxt = '0;
    end else if (!st_r.failed) begin
      if (st_r.in_prefix) begin
        if (!digit) begin
          st_nxt.failed = 1'b1;
        end else begin
          st_nxt.prefix    = (pre_acc > PreAccW'(ipcv_pkg::PrefixSat)) ?
                             ipcv_pkg::PrefixSat : pre_acc[ipcv_pkg::PrefixW-1:0];
          st_nxt.has_digit = 1'b1;
        end
      end else if (ch == ipcv_pkg::CharSlash) begin
        if (st_r.dot_count != ipcv_pkg::LastDot || !st_r.has_digit) begin
          st_nxt.failed = 1'b1;
        end else begin
          st_nxt.in_prefix = 1'b1;
          st_nxt.has_digit = 1'b0;
          st_nxt.octet     = '0;
          st_nxt.prefix    = '0;
        end
      end else if (ch == ipcv_pkg::CharDot) begin
        if (!st_r.has_digit || st_r.dot_count == ipcv_pkg::LastDot) begin
          st_nxt.failed = 1'b1;
        end else begin
          st_nxt.dot_count = st_r.dot_count + 1'b1;
          st_nxt.has_digit = 1'b0;
          st_nxt.octet     = '0;
        end
      end else if (!digit || oct_acc > OctAccW'(ipcv_pkg::MaxOctet)) begin
        st_nxt.failed = 1'b1;
      end else begin
        st_nxt.octet     = oct_acc[ipcv_pkg::OctetW-1:0];
        st_nxt.has_digit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  assign ok = !st_r.failed && st_r.in_prefix && st_r.has_digit &&
              (st_r.prefix >= bounds.min_prefix) && (st_r.prefix <= bounds.max_prefix);

  assign res.ok         = ok;
  assign res.prefix_len = ok ? st_r.prefix : '0;

endmodule

@@ rtl/ipv4_cidr_string_validator_top.sv @@
// ipv4_cidr_string_validator_top: streaming checker for A.B.C.D/P strings
// depends on ipcv_pkg and ipcv_parser
//
//   channel | dir | ports                          | one word carries
//   --------+-----+--------------------------------+------------------------------
//   in      | in  | in_tvalid/in_tready/in_tdata/  | one character or end marker
//           |     | in_tuser                       |
//   out     | out | out_tvalid/out_tready/out_tdata| verdict for one whole string
//   cfg     | in  | cfg_we/cfg_index/cfg_wdata     | one prefix bound register
//
// one word per cycle sustained unless an end marker stalls; a word is registered in the input
// stage, where the parser updates its state, and an end marker loads the verdict into the
// output register, which drives out_tvalid
// rst_n (synchronous) clears the stages, the parse state and restores the bounds
// only an end marker waiting on a full output register stalls the input side;
// character words keep flowing while a verdict waits to be taken

module ipv4_cidr_string_validator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ipcv_pkg::CharW-1:0]       in_tdata,   // [7:0] ch
  input  logic                             in_tuser,   // [0] kind (1 = end of string)
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ipcv_pkg::OutDataW-1:0]    out_tdata,  // [0] valid_res, [6:1] prefix_len,
                                                        // [7] zero
  // configuration writes
  input  logic                             cfg_we,
  input  logic [ipcv_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ipcv_pkg::CfgDataW-1:0]    cfg_wdata
);

  // configuration registers
  ipcv_pkg::bounds_t bounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.min_prefix <= ipcv_pkg::MinPrefixRst;
      bounds_r.max_prefix <= ipcv_pkg::MaxPrefixRst;
    end else if (cfg_we) begin
      case (cfg_index)
        ipcv_pkg::CfgIdxMinPrefix: bounds_r.min_prefix <= cfg_wdata;
        ipcv_pkg::CfgIdxMaxPrefix: bounds_r.max_prefix <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  logic                         stg_valid_r, stg_valid_nxt;
  logic                         stg_kind_r;
  logic [ipcv_pkg::CharW-1:0]   stg_ch_r;
  logic                         out_free;
  logic                         stg_advance;
  logic                         in_accept;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  ipcv_pkg::result_t            out_res_r;
  ipcv_pkg::result_t            parse_res;
  logic                         load_result;

  assign out_free    = !out_valid_r || out_tready;
  // a character word never needs the output slot
  assign stg_advance = stg_valid_r && ((stg_kind_r == ipcv_pkg::KindChar) || out_free);
  assign in_tready   = !stg_valid_r || stg_advance;
  assign in_accept   = in_tvalid && in_tready;
  assign load_result = stg_advance && (stg_kind_r == ipcv_pkg::KindEnd);

  assign stg_valid_nxt = in_tready ? in_tvalid : stg_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_kind_r <= in_tuser;
      stg_ch_r   <= in_tdata;
    end
  end

  ipcv_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (stg_advance),
    .kind    (stg_kind_r),
    .ch      (stg_ch_r),
    .bounds  (bounds_r),
    .res     (parse_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_res_r <= parse_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.prefix_len, out_res_r.ok};

endmodule

@@ rtl/ipcv_checker.sv @@
// ipcv_checker: port-level assertions for the validator top level
// depends on ipcv_pkg; bound to ipv4_cidr_string_validator_top below

module ipcv_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [ipcv_pkg::CharW-1:0]       in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ipcv_pkg::OutDataW-1:0]    out_tdata
);

  // an offered input word waits unchanged until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable({in_tuser, in_tdata}))
    else $error("input word changed while stalled");

  // a held verdict keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // a failed string reports a zero prefix and zero padding
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[ipcv_pkg::OutDataW-1:1] == '0)
    else $error("invalid verdict with nonzero prefix");

  // input only stalls behind a pending verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // no verdict straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ipv4_cidr_string_validator_top ipcv_checker u_ipcv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/tb_ipv4_cidr_string_validator_top.sv @@
// self-checking bench for ipv4_cidr_string_validator_top: streams address strings
// through the block and checks each verdict against a built-in parser model
// depends on ipcv_pkg and the rtl of ipv4_cidr_string_validator_top

module tb_ipv4_cidr_string_validator_top;
  import ipcv_pkg::*;

  // one word on the input channel: a character or an end marker
  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] ch;
  } stream_word_t;

  // ways a well-formed string gets broken
  typedef enum int {MangleSwap, MangleDrop, MangleAdd, MangleCut} mangle_t;

  localparam int HoldCycles  = 400;    // long receiver hold-off for the backpressure phase
  localparam int SettleWait  = 6;      // cycles past the last verdict before touching config
  localparam int DrainLimit  = 50000;  // bound on any wait for outstanding verdicts
  localparam int MaxReported = 10;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [CharW-1:0]    in_tdata   = '0;
  logic                in_tuser   = KindChar;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = CfgIdxMinPrefix;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  ipv4_cidr_string_validator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // stimulus and scoreboard storage
  stream_word_t word_q[$];      // words waiting to be offered
  result_t      verdict_q[$];   // verdicts predicted, oldest first
  stream_word_t next_word;
  result_t      due;
  int           words_added    = 0;
  int           err_count      = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_cnt       = 0;
  logic         hold_arm       = 1'b0;

  // bench copy of the prefix bounds
  logic [PrefixW-1:0] bnd_min = MinPrefixRst;
  logic [PrefixW-1:0] bnd_max = MaxPrefixRst;

  // bench copy of the parse state
  logic               p_in_prefix = 1'b0;
  logic [DotW-1:0]    p_dots      = '0;
  logic               p_has_digit = 1'b0;
  logic [OctetW-1:0]  p_octet     = '0;
  logic [PrefixW-1:0] p_prefix    = '0;
  logic               p_failed    = 1'b0;

  // advance the parser model by one accepted word; an end marker yields a verdict
  task automatic judge_word(input logic kind, input logic [CharW-1:0] ch);
    logic    is_digit;
    int      digit;
    int      acc;
    logic    ok;
    result_t verdict;
    is_digit = (ch >= CharZero) && (ch <= CharNine);
    digit    = is_digit ? int'(ch - CharZero) : 0;
    if (kind == KindEnd) begin
      ok = !p_failed && p_in_prefix && p_has_digit &&
           (p_prefix >= bnd_min) && (p_prefix <= bnd_max);
      verdict.ok         = ok;
      verdict.prefix_len = ok ? p_prefix : '0;
      verdict_q.push_back(verdict);
      p_in_prefix = 1'b0;
      p_dots      = '0;
      p_has_digit = 1'b0;
      p_octet     = '0;
      p_prefix    = '0;
      p_failed    = 1'b0;
    end else if (p_failed) begin
      // sticky: ignore everything up to the end marker
    end else if (p_in_prefix) begin
      if (!is_digit) begin
        p_failed = 1'b1;
      end else begin
        acc         = int'(p_prefix) * 10 + digit;
        p_prefix    = (acc > int'(PrefixSat)) ? PrefixSat : PrefixW'(acc);
        p_has_digit = 1'b1;
      end
    end else if (ch == CharSlash) begin
      if (p_dots != LastDot || !p_has_digit) begin
        p_failed = 1'b1;
      end else begin
        p_in_prefix = 1'b1;
        p_has_digit = 1'b0;
        p_octet     = '0;
        p_prefix    = '0;
      end
    end else if (ch == CharDot) begin
      if (!p_has_digit || p_dots == LastDot) begin
        p_failed = 1'b1;
      end else begin
        p_dots      = p_dots + 1'b1;
        p_has_digit = 1'b0;
        p_octet     = '0;
      end
    end else if (!is_digit) begin
      p_failed = 1'b1;
    end else begin
      acc = int'(p_octet) * 10 + digit;
      if (acc > int'(MaxOctet)) begin
        p_failed = 1'b1;
      end else begin
        p_octet     = OctetW'(acc);
        p_has_digit = 1'b1;
      end
    end
  endtask

  // driver: a word leaves the queue only when the previous one was taken or none was up
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        judge_word(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = word_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_word.ch;
          in_tuser  <= next_word.kind;
        end else begin
          in_tvalid <= 1'b0;
          in_tdata  <= 8'($urandom);
          in_tuser  <= 1'($urandom);
        end
      end
    end
  end

  // long receiver hold-off, armed by the sequencer
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_arm) begin
      hold_cnt <= HoldCycles;
    end
  end

  // monitor: compare each taken verdict with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          err_count = err_count + 1;
          if (err_count <= MaxReported)
            $display("unexpected verdict word %h with nothing outstanding", out_tdata);
        end else begin
          due = verdict_q.pop_front();
          if (out_tdata[0] !== due.ok || out_tdata[PrefixW:1] !== due.prefix_len ||
              out_tdata[OutDataW-1] !== 1'b0) begin
            err_count = err_count + 1;
            if (err_count <= MaxReported)
              $display({"verdict mismatch: expected valid=%0b prefix=%0d pad=0, ",
                        "got valid=%0b prefix=%0d pad=%0b"},
                       due.ok, due.prefix_len, out_tdata[0], out_tdata[PrefixW:1],
                       out_tdata[OutDataW-1]);
          end
        end
      end
      out_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [CharW-1:0] pick_noise_char();
    string pool;
    pool = "0123456789./";
    if ($urandom_range(0, 1) == 0)
      return pool[$urandom_range(0, pool.len() - 1)];
    return 8'($urandom);
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      word_q.push_back('{KindChar, s[i]});
      words_added = words_added + 1;
    end
  endtask

  // end marker with a junk character that the block must ignore
  task automatic add_end();
    word_q.push_back('{KindEnd, 8'($urandom)});
    words_added = words_added + 1;
  endtask

  // mostly well-formed addresses with random content, some broken, some pure noise
  task automatic add_random_string();
    logic [CharW-1:0] text_q[$];
    string            txt;
    int               pick;
    int               r;
    int               val;
    int               lo;
    int               hi;
    int               pos;
    mangle_t          how;
    pick = $urandom_range(0, 99);
    txt  = "";
    if (pick < 88) begin
      for (int k = 0; k < 4; k++) begin
        r = $urandom_range(0, 9);
        if (r < 8)
          val = $urandom_range(0, 255);
        else if (r == 8)
          val = $urandom_range(0, 1) ? 255 : 0;
        else
          val = $urandom_range(256, 999);    // octet out of range
        if (k != 0)
          txt = {txt, "."};
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1) == 0)
            txt = {txt, "0"};
          else
            txt = {txt, "00"};
        end
        txt = {txt, $sformatf("%0d", val)};
      end
      // prefix mostly near the current bounds so both edges get hit
      lo = (int'(bnd_min) >= 2) ? int'(bnd_min) - 2 : 0;
      hi = (int'(bnd_max) <= 61) ? int'(bnd_max) + 2 : 63;
      r  = $urandom_range(0, 19);
      if (r < 12)
        val = $urandom_range(lo, hi);
      else if (r < 17)
        val = $urandom_range(0, 63);
      else
        val = $urandom_range(64, 99999);     // saturates
      txt = {txt, "/"};
      if ($urandom_range(0, 9) == 0)
        txt = {txt, "0"};
      txt = {txt, $sformatf("%0d", val)};
      for (int i = 0; i < txt.len(); i++)
        text_q.push_back(txt[i]);
      if (pick >= 70) begin
        repeat ($urandom_range(1, 2)) begin
          how = mangle_t'($urandom_range(0, 3));
          pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
          case (how)
            MangleSwap: begin
              if (text_q.size() != 0)
                text_q[pos] = pick_noise_char();
            end
            MangleDrop: begin
              if (text_q.size() != 0)
                text_q.delete(pos);
            end
            MangleAdd: begin
              text_q.insert(pos, pick_noise_char());
            end
            default: begin
              while (text_q.size() > pos)
                void'(text_q.pop_back());
            end
          endcase
        end
      end
    end else begin
      repeat ($urandom_range(0, 12))
        text_q.push_back(pick_noise_char());
    end
    foreach (text_q[i]) begin
      word_q.push_back('{KindChar, text_q[i]});
      words_added = words_added + 1;
    end
    add_end();
  endtask

  // nothing queued, nothing on the bus and nothing outstanding, then let the pipe settle
  task automatic wait_drained();
    for (int i = 0; i < DrainLimit; i++) begin
      if (word_q.size() == 0 && !in_tvalid && verdict_q.size() == 0)
        break;
      @(negedge clk);
    end
    repeat (SettleWait) @(negedge clk);
  endtask

  // both bounds are rewritten each time; only called with the block idle
  task automatic write_bounds(input logic [PrefixW-1:0] lo, input logic [PrefixW-1:0] hi);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CfgIdxMinPrefix;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CfgIdxMaxPrefix;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bnd_min = lo;
    bnd_max = hi;
    @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int word_budget);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = words_added + word_budget;
    while (words_added < target)
      add_random_string();
    wait_drained();
  endtask

  // sequencer: all queue and knob updates happen on the falling edge
  initial begin
    string directed_set[$];
    int    lo;
    directed_set = '{
      "255.255.255.255/31",  // largest octets, prefix at the upper bound
      "0.0.0.0/1",           // smallest octets, prefix at the lower bound
      "1.2.3.4/0",           // prefix under the lower bound
      "1.2.3.4/32",          // prefix over the upper bound
      "1.2.3.256/8",         // octet above 255
      "1..3.4/8",            // empty octet
      "1.2.3.4.5/8",         // fifth octet
      "1.2.3/8",             // slash before the third dot
      "1.2.3./8",            // empty last octet before the slash
      "1.2.3.4",             // no prefix part at all
      "1.2.3.4/",            // empty prefix
      "1.2.3.4/1/",          // second slash in the prefix
      "1.2.3.4/2a",          // letter in the prefix
      "x1.2.3.4/8",          // stray character, rest ignored after failure
      "1.2.3.4/999",         // prefix saturates, then fails the upper bound
      ""                     // end marker on its own
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed strings under the reset bounds, no idling
    foreach (directed_set[i]) begin
      add_text(directed_set[i]);
      add_end();
    end
    wait_drained();

    // widest bounds, no idling
    write_bounds(6'd0, 6'd63);
    run_phase(0, 0, 180);

    // random ordered bounds, sparse sender
    lo = $urandom_range(0, 63);
    write_bounds(PrefixW'(lo), PrefixW'($urandom_range(lo, 63)));
    run_phase(87, 0, 180);

    // both bounds at the top, slow receiver
    write_bounds(6'd63, 6'd63);
    run_phase(0, 87, 180);

    // lower bound above the upper one: nothing may pass
    write_bounds(PrefixW'($urandom_range(33, 63)), PrefixW'($urandom_range(0, 31)));
    run_phase(17, 17, 80);

    // both bounds at zero while the receiver holds off long enough to stall the input
    write_bounds(6'd0, 6'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_arm       = 1'b1;
    while (hold_cnt == 0)
      @(negedge clk);
    hold_arm = 1'b0;
    run_phase(0, 0, 130);

    // fully random bounds and idling
    write_bounds(PrefixW'($urandom), PrefixW'($urandom));
    run_phase($urandom_range(0, 90), $urandom_range(0, 90), 90);

    repeat (20) @(negedge clk);
    if (err_count == 0 && verdict_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
